@@ rtl/ssps_pkg.sv @@
// Shared constants and coefficient table for the sixth-order plant update.
// Depends on nothing; every other file in rtl imports it.
`default_nettype none

package ssps_pkg;

   localparam int NSTATE  = 6;
   localparam int NCOEF   = 7;
   localparam int OUT_ROW = 5;

   // Coefficients in units of 1e-4. Rows and columns follow the state order
   // i1, u1, i2, u2, i3, u3; the last column weights the drive voltage.
   localparam int COEF_E4 [NSTATE][NCOEF] = '{
      '{  9652,  -172,    57,   -58,    52,  -251,  471 },
      '{  7732,  1252,  2315,   700,  1282,  7754,  377 },
      '{  8278, -7522,  -956,  3299, -4855,  3915,  404 },
      '{  9948,  2655, -3848,  4212,  3927,  2899,  485 },
      '{  7648, -4165, -4855, -3366,  -986,  7281,  373 },
      '{ 11056,  7587,  1179,   748, -2192,  1491,  539 }
   };

   // Fixed-point coefficient with frac fractional bits, rounded to nearest
   // with ties away from zero. Only ever evaluated on constants.
   function automatic longint coef_q(input int row, input int col, input int frac);
      longint e4;
      longint mag;
      e4  = longint'(COEF_E4[row][col]);
      mag = (((e4 < 0) ? -e4 : e4) <<< frac) + 64'sd5000;
      mag = mag / 64'sd10000;
      return (e4 < 0) ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ssps_row.sv @@
// One row of the state update: seven constant-coefficient products, their
// full-precision sum, round half up and saturation. Depends on ssps_pkg.
`default_nettype none

module ssps_row #(
   parameter int DATA_WIDTH     = 24,
   parameter int COEF_FRAC_BITS = 14,
   parameter int ROW            = 0
) (
   input  wire logic [ssps_pkg::NSTATE-1:0][DATA_WIDTH-1:0] state_i,
   input  wire logic signed [DATA_WIDTH-1:0]                drive_i,
   output logic signed [DATA_WIDTH-1:0]                     next_o
);
   import ssps_pkg::*;

   // Coefficient magnitudes stay below 2.0, so two integer bits suffice.
   localparam int CW = COEF_FRAC_BITS + 2;
   localparam int PW = DATA_WIDTH + CW;
   localparam int AW = PW + 3;
   localparam int RW = AW - COEF_FRAC_BITS;

   localparam logic signed [AW-1:0] HALF = AW'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [RW-1:0] SAT_MAX = RW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [RW-1:0] SAT_MIN = -SAT_MAX - RW'(1);

   logic signed [DATA_WIDTH-1:0] operand [NCOEF];
   logic signed [PW-1:0]         prod    [NCOEF];
   logic signed [AW-1:0]         acc;
   logic signed [AW-1:0]         acc_half;
   logic signed [RW-1:0]         rounded;

   always_comb begin
      for (int c = 0; c < NSTATE; c++) begin
         operand[c] = $signed(state_i[c]);
      end
      operand[NSTATE] = drive_i;
   end

   // Each product has a constant operand, so these reduce to adder trees.
   always_comb begin
      for (int c = 0; c < NCOEF; c++) begin
         prod[c] = PW'(operand[c]) * PW'(CW'(coef_q(ROW, c, COEF_FRAC_BITS)));
      end
   end

   always_comb begin
      acc = '0;
      for (int c = 0; c < NCOEF; c++) begin
         acc = acc + AW'(prod[c]);
      end
   end

   assign acc_half = acc + HALF;
   assign rounded  = RW'(acc_half >>> COEF_FRAC_BITS);

   always_comb begin
      if (rounded > SAT_MAX) begin
         next_o = DATA_WIDTH'(SAT_MAX);
      end else if (rounded < SAT_MIN) begin
         next_o = DATA_WIDTH'(SAT_MIN);
      end else begin
         next_o = DATA_WIDTH'(rounded);
      end
   end

endmodule

`default_nettype wire

@@ rtl/state_space_plant_step.sv @@
// Sixth-order discrete plant x(k+1) = A*x(k) + B*u; built from ssps_pkg and ssps_row.
// An accepted item waits in the input stage; when it advances, its result is registered.
// Throughput: one item per cycle while the result side is not stalled by rsp_ready.
// Reset (synchronous, active high) clears the six state words and both valid flags.
`default_nettype none

module state_space_plant_step #(
   parameter int DATA_WIDTH     = 24,
   parameter int COEF_FRAC_BITS = 14
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [DATA_WIDTH-1:0] req_drive_voltage,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0]      rsp_output_voltage
);
   import ssps_pkg::*;

   // Input stage: the accepted drive sample waits here for its state update.
   logic                         in_valid_ff, in_valid_in;
   logic signed [DATA_WIDTH-1:0] drive_ff;

   // Plant state in the order i1, u1, i2, u2, i3, u3. It is written in the
   // same cycle that a result is loaded, so the next item in the input stage
   // always sees the state left by the item before it.
   logic [NSTATE-1:0][DATA_WIDTH-1:0] state_ff;
   logic [NSTATE-1:0][DATA_WIDTH-1:0] state_in;

   // Result stage.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] out_ff;

   logic accept;
   logic advance;

   // The input stage moves on when the result register is empty or is being
   // drained in the same cycle; a new item may enter behind it at once.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // All six rows read the old state and are written back together.
   for (genvar r = 0; r < NSTATE; r++) begin : g_row
      logic signed [DATA_WIDTH-1:0] row_next;

      ssps_row #(
         .DATA_WIDTH     (DATA_WIDTH),
         .COEF_FRAC_BITS (COEF_FRAC_BITS),
         .ROW            (r)
      ) u_row (
         .state_i (state_ff),
         .drive_i (drive_ff),
         .next_o  (row_next)
      );

      assign state_in[r] = row_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset; the valid flags qualify them.
   always_ff @(posedge clock) begin
      if (accept) begin
         drive_ff <= req_drive_voltage;
      end
      if (advance) begin
         out_ff <= $signed(state_in[OUT_ROW]);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_output_voltage = out_ff;

`ifndef SYNTHESIS
   // A stalled result must not be dropped or overwritten by a waiting item.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_ready |=> in_valid_ff && rsp_valid_ff
      && $stable(out_ff))
      else $error("result overwritten while stalled");

   // Every state update presents the new third capacitor voltage as result.
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && (out_ff == $signed(state_ff[OUT_ROW])))
      else $error("result does not match updated state");

   // The state moves only when an item leaves the input stage.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("plant state changed without an item");

   // An empty input stage always takes a new item.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_state_space_plant_step.sv @@
// Self-checking testbench for state_space_plant_step, the sixth-order plant update.
// Depends only on the RTL; it keeps its own copy of the coefficient table and the
// plant state, and predicts every output voltage in signed Q12.12.
`default_nettype none

module tb_state_space_plant_step;

   localparam int DW         = 24;
   localparam int FRAC       = 14;
   localparam int ORDER      = 6;
   localparam int TAPS       = 7;
   localparam int U3_ROW     = 5;
   localparam int DIRECTED_N = 22;
   localparam int RANDOM_N   = 900;
   localparam int CALM_TAIL  = 150;
   localparam int HOLD_AT    = 300;
   localparam int HOLD_LEN   = 48;
   localparam int DRAIN_WAIT = 8;
   localparam int CYCLE_LIMIT = 200000;

   localparam logic signed [DW-1:0] V_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] V_MIN = {1'b1, {(DW-1){1'b0}}};

   // Plant matrix [A | B] in units of 1e-4. Columns follow the state order
   // i1, u1, i2, u2, i3, u3, and the last column weights the drive voltage.
   localparam int PLANT_E4 [ORDER][TAPS] = '{
      '{  9652,  -172,    57,   -58,    52,  -251,  471 },
      '{  7732,  1252,  2315,   700,  1282,  7754,  377 },
      '{  8278, -7522,  -956,  3299, -4855,  3915,  404 },
      '{  9948,  2655, -3848,  4212,  3927,  2899,  485 },
      '{  7648, -4165, -4855, -3366,  -986,  7281,  373 },
      '{ 11056,  7587,  1179,   748, -2192,  1491,  539 }
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic signed [DW-1:0] req_drive_voltage;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [DW-1:0] rsp_output_voltage;

   // Pending drive samples, filled once at the start and drained by the driver.
   logic signed [DW-1:0] pending_drive[$];
   // Predicted output voltages, oldest first.
   logic signed [DW-1:0] expected_voltage[$];
   // The testbench's own copy of the plant state x(k).
   logic signed [DW-1:0] plant_x [ORDER];

   logic signed [DW-1:0] oldest_voltage;
   int                   mismatch_count;
   int                   accepted_count;
   int                   cycle_count;
   int                   send_gap;
   int                   recv_stall;
   int                   hold_left;
   logic                 hold_done;
   logic                 req_taken;

   state_space_plant_step #(
      .DATA_WIDTH     (DW),
      .COEF_FRAC_BITS (FRAC)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_drive_voltage  (req_drive_voltage),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_output_voltage (rsp_output_voltage)
   );

   // Converts a coefficient in units of 1e-4 to FRAC fractional bits. The
   // magnitude is rounded to nearest, so ties go away from zero.
   function automatic longint coef_fixed(input int tenthousandths);
      longint mag;
      mag = (tenthousandths < 0) ? -longint'(tenthousandths) : longint'(tenthousandths);
      mag = (mag * (longint'(1) <<< FRAC) + 64'sd5000) / 64'sd10000;
      return (tenthousandths < 0) ? -mag : mag;
   endfunction

   // One plant step: every row sums its seven exact products from the old
   // state, rounds half up to Q12.12 and clamps to the signed DW-bit range.
   // The new state replaces the old one at once, and u3 is returned.
   function automatic logic signed [DW-1:0] plant_update(input logic signed [DW-1:0] drive);
      logic signed [DW-1:0] next_x [ORDER];
      longint               acc;
      for (int r = 0; r < ORDER; r++) begin
         acc = longint'(drive) * coef_fixed(PLANT_E4[r][ORDER]);
         for (int c = 0; c < ORDER; c++) begin
            acc += longint'(plant_x[c]) * coef_fixed(PLANT_E4[r][c]);
         end
         acc = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
         if (acc > longint'(V_MAX)) begin
            next_x[r] = V_MAX;
         end else if (acc < longint'(V_MIN)) begin
            next_x[r] = V_MIN;
         end else begin
            next_x[r] = acc[DW-1:0];
         end
      end
      for (int r = 0; r < ORDER; r++) begin
         plant_x[r] = next_x[r];
      end
      return plant_x[U3_ROW];
   endfunction

   task automatic report_mismatch(input string what, input logic signed [DW-1:0] got,
                                  input logic signed [DW-1:0] want);
      $display("MISMATCH cycle %0d: %s, output_voltage got %0d expected %0d",
               cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Idling is allowed once the directed items are through, and is switched
   // off again for the last stretch of the run so that it ends at full rate.
   function automatic logic idle_allowed();
      return (accepted_count >= DIRECTED_N) && (pending_drive.size() > CALM_TAIL);
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Every input of the block is known from time zero. Reset is held high
   // at the start and released on a falling edge.
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_drive_voltage = '0;
      rsp_ready         = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Timeout watchdog, reckoned from the slowest legal run several times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_state_space_plant_step NOT OK");
         $finish;
      end
   end

   // The driver offers the next sample on the falling edge once the previous
   // item was taken. After an item it may insert a short idle burst, except
   // while the receiver holds off, so that the block really fills and stalls.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_drive.size() > 0) begin
            req_valid         <= 1'b1;
            req_drive_voltage <= pending_drive.pop_front();
            if (idle_allowed() && hold_left == 0 && $urandom_range(0, 5) == 0) begin
               send_gap <= $urandom_range(1, 9);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiver drops ready in random bursts, and stays low for the whole
   // hold-off stretch counted by the process below.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_allowed() && $urandom_range(0, 5) == 0) begin
            recv_stall <= $urandom_range(1, 9);
         end
      end
   end

   // One long hold-off of the result side, started once a few hundred items
   // have gone in. The block has only a short pipeline, so its input stalls.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end
   end

   // Monitor: results are checked before this edge's input item is predicted,
   // since an item cannot produce its result on the edge that accepts it.
   always @(posedge clock) begin
      if (reset) begin
         req_taken      <= 1'b0;
         accepted_count <= 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_voltage.size() == 0) begin
               report_mismatch("result with no item pending", rsp_output_voltage, '0);
            end else begin
               oldest_voltage = expected_voltage.pop_front();
               if (rsp_output_voltage !== oldest_voltage) begin
                  report_mismatch("wrong value", rsp_output_voltage, oldest_voltage);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_voltage.push_back(plant_update(req_drive_voltage));
            accepted_count <= accepted_count + 1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int                   kind;
      int                   seg_len;
      logic signed [DW-1:0] level;
      mismatch_count = 0;
      cycle_count    = 0;
      for (int i = 0; i < ORDER; i++) begin
         plant_x[i] = '0;
      end

      // Directed part. From the cleared state, -8192 makes the u3 row land
      // exactly halfway between two Q12.12 steps, so half-up rounding shows.
      // Then the field extremes, alternating bit patterns, and long runs of
      // full-scale drive of each sign to push the rows into saturation.
      pending_drive.push_back('0);
      pending_drive.push_back(-24'sd8192);
      pending_drive.push_back(24'sd1);
      pending_drive.push_back(-24'sd1);
      pending_drive.push_back(V_MAX);
      pending_drive.push_back(V_MIN);
      pending_drive.push_back(24'h555555);
      pending_drive.push_back(24'hAAAAAA);
      repeat (6) pending_drive.push_back(V_MAX);
      repeat (6) pending_drive.push_back(V_MIN);
      pending_drive.push_back('0);
      pending_drive.push_back('0);

      // Random part in short segments of one flavor each: full-range noise,
      // small signals near zero, a held level, sign-alternating extremes and
      // plain zero input.
      while (pending_drive.size() < DIRECTED_N + RANDOM_N) begin
         kind    = $urandom_range(0, 4);
         seg_len = $urandom_range(1, 20);
         level   = DW'($urandom);
         for (int k = 0; k < seg_len; k++) begin
            case (kind)
               0: pending_drive.push_back(DW'($urandom));
               1: pending_drive.push_back(($urandom_range(0, 1) == 0) ?
                                          DW'($urandom_range(0, 8191)) :
                                          -DW'($urandom_range(0, 8192)));
               2: pending_drive.push_back(level);
               3: pending_drive.push_back((k % 2 == 0) ? V_MAX : V_MIN);
               default: pending_drive.push_back('0);
            endcase
         end
      end

      @(negedge clock);
      while (reset) @(negedge clock);
      while (pending_drive.size() != 0 || req_valid) @(posedge clock);
      while (expected_voltage.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_state_space_plant_step OK");
      end else begin
         $display("tb_state_space_plant_step NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ state_space_plant_step.f @@
rtl/ssps_pkg.sv
rtl/ssps_row.sv
rtl/state_space_plant_step.sv
tb/sv/tb_state_space_plant_step.sv
